/* design/run_limited_string_enumerator_unit_macros.svh */
// Assertion macros for the run-limited string enumerator.
// Used by the top level; relies on clk and rst in the including scope.
`ifndef RUN_LIMITED_STRING_ENUMERATOR_UNIT_MACROS_SVH
`define RUN_LIMITED_STRING_ENUMERATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define RLSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RLSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RLSE_ASSERT(lbl, prop, msg)
`define RLSE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/rlse_pkg.sv */
// Shared types and constants for the run-limited string enumerator.
// No dependencies; imported by rlse_cell and the top level.
`default_nettype none

package rlse_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int CFG_W       = 7;
  localparam int PAT_W       = 64;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN = 1'b1;

  localparam logic [CFG_W-1:0] SEQ_LEN_RST = 7'd8;
  localparam logic [CFG_W-1:0] MAX_RUN_RST = 7'd2;

  // Scan token walking down the cell row, MSB first.
  typedef struct packed {
    logic             vld;
    logic             seen;      // at least one settable zero so far
    logic             seen2;     // at least two settable zeros so far
    logic [CFG_W-1:0] run;       // ones directly above the current cell
    logic [CFG_W-1:0] pick;      // index of the lowest settable zero so far
    logic [CFG_W-1:0] pick_run;  // ones directly above that zero
  } token_t;

  // Update broadcast to every cell.
  typedef struct packed {
    logic             en;
    logic             clr;
    logic [CFG_W-1:0] pick;
    logic [CFG_W-1:0] top;
  } apply_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_PUSH  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

/* design/rlse_cell.sv */
// One bit cell of the enumerator row: holds a string bit and one token slot.
// Depends on rlse_pkg.
`default_nettype none

module rlse_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rlse_pkg::CFG_W-1:0] max_run,
  input  logic                      inject,
  input  rlse_pkg::token_t          tok_in,
  output rlse_pkg::token_t          tok_out,
  input  rlse_pkg::apply_t          upd,
  output logic                      cur
);
  import rlse_pkg::*;

  localparam logic [CFG_W-1:0] MY_IDX = CFG_W'(IDX);

  token_t         tok;
  token_t         tok_seed;
  logic           val;
  logic           cand;
  logic [CFG_W:0] run_inc;

  assign run_inc = {1'b0, tok.run} + (CFG_W+1)'(1);
  // A zero here can be set if the run it would end stays below the limit.
  assign cand    = tok.vld && !val && (run_inc < {1'b0, max_run});

  // Fresh token: valid, no ones above, nothing seen yet.
  always_comb begin
    tok_seed     = '0;
    tok_seed.vld = 1'b1;
  end

  always_comb begin
    tok_out = '0;
    if (tok.vld) begin
      tok_out.vld      = 1'b1;
      tok_out.seen     = tok.seen | cand;
      tok_out.seen2    = tok.seen2 | (tok.seen & cand);
      tok_out.run      = val ? run_inc[CFG_W-1:0] : '0;
      tok_out.pick     = cand ? MY_IDX : tok.pick;
      tok_out.pick_run = cand ? tok.run : tok.pick_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else if (inject) begin
      tok <= tok_seed;
    end else begin
      tok <= tok_in;
    end
  end

  // On restart clear every bit; else keep bits above the pick, set the pick, clear below it and past the length.
  always_ff @(posedge clk) begin
    if (upd.en) begin
      if (upd.clr || (MY_IDX > upd.top) || (MY_IDX < upd.pick)) begin
        val <= 1'b0;
      end else if (MY_IDX == upd.pick) begin
        val <= 1'b1;
      end
    end
  end

  assign cur = val;

endmodule

`default_nettype wire

/* design/run_limited_string_enumerator_unit.sv */
// Run-limited binary string enumerator, top level.
// Next request: the scan token enters the top active cell and walks the cell row
//   one cell per cycle to bit zero; then the update is applied and the result pushed
//   (pushed directly when no successor remains). Restart: apply, then push.
// Request after exhaustion: pushed directly. One request in flight at a time.
// Synchronous active-high reset: seq_len 8, max_run 2, nothing started.
// Depends on rlse_pkg, rlse_cell and the assertion macro header.
`default_nettype none
`include "run_limited_string_enumerator_unit_macros.svh"

module run_limited_string_enumerator_unit #(
  parameter int MAX_LEN = rlse_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rlse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlse_pkg::CFG_W-1:0]     cfg_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          restart,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rlse_pkg::PAT_W-1:0]     pattern,
  output logic                          pattern_valid,
  output logic                          final_pattern
);
  import rlse_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] seq_len;
  logic [CFG_W-1:0] max_run;

  // Controller state.
  state_t           state;
  logic             started;
  logic             exhausted;
  logic             clr_r;
  logic             res_vld;
  logic             fin_r;
  token_t           tok_fin;

  logic [CFG_W-1:0] top_idx;
  logic             go_restart;
  logic             inject;
  logic             fin_calc;
  apply_t           upd;

  // Cell row: link[i] is the token leaving cell i; link[MAX_LEN] feeds the top.
  token_t           link [MAX_LEN+1];
  logic [MAX_LEN-1:0] cells;
  logic [MAX_LEN-1:0] tok_vld;

  // Writes are taken at any time; software must write only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= SEQ_LEN_RST;
      max_run <= MAX_RUN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SEQ_LEN: seq_len <= cfg_data;
        REG_MAX_RUN: max_run <= cfg_data;
        default: ;
      endcase
    end
  end

  // Highest active bit index: length clamped to one through MAX_LEN, minus one.
  always_comb begin
    if (seq_len == '0) begin
      top_idx = '0;
    end else if (seq_len > CFG_W'(MAX_LEN)) begin
      top_idx = CFG_W'(MAX_LEN - 1);
    end else begin
      top_idx = seq_len - CFG_W'(1);
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign go_restart = restart || !started;
  // Launch a scan token into the top active cell.
  assign inject     = in_valid && in_ready && !go_restart && !exhausted;

  assign upd.en   = (state == S_APPLY);
  assign upd.clr  = clr_r;
  assign upd.pick = tok_fin.pick;
  assign upd.top  = top_idx;

  // Last-string test for the value being written now. After a restart the
  // all-zeros string is last only when no one may ever be placed. After a
  // successor, another settable zero remains if one lay above the pick, if
  // the pick sits two or more places up (the zero below it is free), or if
  // the pick sits at bit one and the run it leaves still permits bit zero.
  always_comb begin
    if (clr_r) begin
      fin_calc = (max_run < CFG_W'(2));
    end else begin
      fin_calc = !(tok_fin.seen2 ||
                   (tok_fin.pick >= CFG_W'(2)) ||
                   ((tok_fin.pick == CFG_W'(1)) &&
                    (({1'b0, tok_fin.pick_run} + (CFG_W+1)'(2)) < {1'b0, max_run})));
    end
  end

  assign link[MAX_LEN] = '0;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic inj_here;
    assign inj_here   = inject && (CFG_W'(i) == top_idx);
    assign tok_vld[i] = link[i].vld;

    rlse_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .max_run (max_run),
      .inject  (inj_here),
      .tok_in  (link[i+1]),
      .tok_out (link[i]),
      .upd     (upd),
      .cur     (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      exhausted <= 1'b0;
      clr_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a push below refills it this cycle.
      if (out_valid && out_ready && (state != S_PUSH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (go_restart) begin
              started   <= 1'b1;
              exhausted <= 1'b0;
              clr_r     <= 1'b1;
              state     <= S_APPLY;
            end else if (exhausted) begin
              res_vld <= 1'b0;
              state   <= S_PUSH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Token has reached bit zero: hold its summary.
          if (link[0].vld) begin
            tok_fin <= link[0];
            if (link[0].seen) begin
              clr_r <= 1'b0;
              state <= S_APPLY;
            end else begin
              exhausted <= 1'b1;
              res_vld   <= 1'b0;
              state     <= S_PUSH;
            end
          end
        end
        S_APPLY: begin
          fin_r   <= fin_calc;
          res_vld <= 1'b1;
          state   <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            pattern       <= res_vld ? PAT_W'(cells) : '0;
            pattern_valid <= res_vld;
            final_pattern <= res_vld & fin_r;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Only one token may travel the row.
  `RLSE_ASSERT(a_one_token, $onehot0(tok_vld), "more than one scan token in the cell row")
  // A successor update never picks a bit past the active length.
  `RLSE_ASSERT(a_pick_range, (state == S_APPLY && !clr_r) |-> (tok_fin.pick <= top_idx),
               "pick index beyond string length")
  // An exhausted result carries no string and no last mark.
  `RLSE_ASSERT(a_exh_clean, (out_valid && !pattern_valid) |->
               (pattern == '0 && !final_pattern), "exhausted result not cleared")
  // A push that finds room returns the controller to idle with a result.
  `RLSE_ASSERT_NEXT(a_push_done, (state == S_PUSH && (!out_valid || out_ready)),
                    (out_valid && state == S_IDLE), "result push did not complete")

endmodule

`default_nettype wire
